// File: rtl/core/gf2m_pkg.sv
`default_nettype none

package gf2m_pkg;

  // Widths fixed by the field and register definitions.
  localparam int ELEM_W     = 16;
  localparam int POLY_W     = 17;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 4;

  // Bits of the multiplier operand consumed per multiply step.
  localparam int DIGIT_BITS = 8;

  // Register reset values.
  localparam logic [POLY_W-1:0]  IRR_RESET   = 17'd13;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd3;

  // Input item commands.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } command_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_IRREDUCIBLE = 1'b0,
    CFG_COUNT       = 1'b1
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_LOAD,
    ST_STEP,
    ST_ACC,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mem_write;
    logic start_eval;
    logic load_c0;
    logic clear_y;
    logic step;
    logic load_term;
    logic first_term;
    logic accumulate;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [COUNT_W-1:0] coefficient_count;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/gf2m_datapath.sv
`default_nettype none

module gf2m_datapath
  import gf2m_pkg::*;
#(
  parameter int MAX_COEFFS = 16,
  parameter int FIELD_BITS = 16,
  localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic [INDEX_W-1:0]    coefficient_index,
  input  logic [ELEM_W-1:0]     coefficient_value,
  input  logic [ELEM_W-1:0]     point_value,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [POLY_W-1:0]     cfg_data,
  output dp_status_t            status,
  output logic [ELEM_W-1:0]     eval_result
);

  localparam int NDIG = (FIELD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int BW   = NDIG * DIGIT_BITS;

  logic [FIELD_BITS-1:0] mem [MAX_COEFFS];
  logic [FIELD_BITS-1:0] rd_data;
  logic [FIELD_BITS-1:0] pt_reg;
  logic [ELEM_W-1:0]     x_reg;
  logic [ELEM_W-1:0]     acc1;
  logic [ELEM_W-1:0]     acc2;
  logic [BW-1:0]         b1;
  logic [BW-1:0]         b2;
  logic [ELEM_W-1:0]     y;
  logic [ELEM_W-1:0]     result;
  logic [POLY_W-1:0]     poly;
  logic [COUNT_W-1:0]    count;
  logic [POLY_W-1:0]     top;
  logic                  zero_field;
  logic [ELEM_W-1:0]     step1;
  logic [ELEM_W-1:0]     step2;
  logic                  idx_ok;

  // One digit of an interleaved multiply: shift, reduce the top bit, add the operand.
  function automatic logic [ELEM_W-1:0] mul_digit(
    input logic [ELEM_W-1:0]     acc_in,
    input logic [ELEM_W-1:0]     a,
    input logic [DIGIT_BITS-1:0] d,
    input logic [POLY_W-1:0]     p,
    input logic [POLY_W-1:0]     tm
  );
    logic [ELEM_W-1:0] acc;
    logic [POLY_W-1:0] s;
    acc = acc_in;
    for (int k = DIGIT_BITS - 1; k >= 0; k--) begin
      s = {acc, 1'b0};
      if ((s & tm) != '0) begin
        s = s ^ p;
      end
      acc = s[ELEM_W-1:0] ^ (d[k] ? a : '0);
    end
    return acc;
  endfunction

  // Leading term of the field polynomial as a one-hot mask.
  always_comb begin
    top = '0;
    for (int i = 0; i < POLY_W; i++) begin
      if (poly[i]) begin
        top = POLY_W'(1) << i;
      end
    end
  end

  // A polynomial of degree zero (or none) makes every product zero.
  assign zero_field = (poly[POLY_W-1:1] == '0);

  assign step1 = mul_digit(acc1, x_reg, b1[BW-1 -: DIGIT_BITS], poly, top);
  assign step2 = mul_digit(acc2, x_reg, b2[BW-1 -: DIGIT_BITS], poly, top);

  assign idx_ok = (int'(coefficient_index) < MAX_COEFFS);

  // Coefficient memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.mem_write && idx_ok) begin
      mem[IDX_W'(coefficient_index)] <= coefficient_value[FIELD_BITS-1:0];
    end
    rd_data <= mem[rd_addr];
  end

  // Multiply operands and partial products.
  always_ff @(posedge clk) begin
    if (cmd.start_eval) begin
      pt_reg <= point_value[FIELD_BITS-1:0];
      x_reg  <= ELEM_W'(1);
      b1     <= BW'(point_value[FIELD_BITS-1:0]);
      b2     <= '0;
      acc1   <= '0;
      acc2   <= '0;
    end else if (cmd.step) begin
      acc1 <= step1;
      acc2 <= step2;
      b1   <= b1 << DIGIT_BITS;
      b2   <= b2 << DIGIT_BITS;
    end else if (cmd.load_term) begin
      if (zero_field) begin
        x_reg <= '0;
      end else if (cmd.first_term) begin
        x_reg <= acc1;
      end else begin
        x_reg <= acc2;
      end
      b1   <= BW'(rd_data);
      b2   <= BW'(pt_reg);
      acc1 <= '0;
      acc2 <= '0;
    end
  end

  // Running sum and the result register.
  always_ff @(posedge clk) begin
    if (cmd.clear_y) begin
      y <= '0;
    end else if (cmd.load_c0) begin
      y <= ELEM_W'(rd_data);
    end else if (cmd.accumulate || (cmd.load_term && !cmd.first_term)) begin
      y <= y ^ acc1;
    end
    if (cmd.out_load) begin
      result <= y;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly  <= IRR_RESET;
      count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IRREDUCIBLE: poly  <= cfg_data;
        CFG_COUNT:       count <= cfg_data[COUNT_W-1:0];
        default:         poly  <= poly;
      endcase
    end
  end

  assign status.coefficient_count = count;
  assign eval_result = result;

endmodule

`default_nettype wire

// File: rtl/core/gf2m_ctrl.sv
`default_nettype none

module gf2m_ctrl
  import gf2m_pkg::*;
#(
  parameter int MAX_COEFFS = 16,
  parameter int FIELD_BITS = 16,
  localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             command,
  input  logic             out_ready,
  input  dp_status_t       status,
  output logic             in_ready,
  output logic             out_valid,
  output ctrl_cmd_t        cmd,
  output logic [IDX_W-1:0] rd_addr
);

  localparam int NDIG  = (FIELD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIG_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int NC_W  = $clog2(MAX_COEFFS + 1);
  localparam int CW    = (NC_W > COUNT_W) ? NC_W : COUNT_W;

  state_t           state;
  state_t           state_next;
  logic [DIG_W-1:0] dig;
  logic [CW-1:0]    term;
  logic [CW-1:0]    count_ext;
  logic [CW-1:0]    n_eff;
  logic             dig_last;
  logic             accept;
  logic             out_free;

  // Number of terms in use, saturated to the store depth.
  assign count_ext = CW'(status.coefficient_count);
  assign n_eff     = (count_ext > CW'(MAX_COEFFS)) ? CW'(MAX_COEFFS) : count_ext;

  assign dig_last = (dig == DIG_W'(NDIG - 1));
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The store is read at the constant term while idle, else at the next term.
  assign rd_addr = (state == ST_IDLE) ? '0 : term[IDX_W-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_EVAL)) begin
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        if (dig_last) begin
          state_next = (n_eff > CW'(1)) ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (dig_last) begin
          state_next = (term < n_eff) ? ST_LOAD : ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd            = '0;
    cmd.mem_write  = accept && (command == CMD_WRITE);
    case (state)
      ST_IDLE: begin
        cmd.start_eval = accept && (command == CMD_EVAL);
      end
      ST_PRE: begin
        cmd.step    = 1'b1;
        cmd.load_c0 = (dig == '0) && (n_eff != '0);
        cmd.clear_y = (dig == '0) && (n_eff == '0);
      end
      ST_LOAD: begin
        cmd.load_term  = 1'b1;
        cmd.first_term = (term == CW'(1));
      end
      ST_STEP: begin
        cmd.step = 1'b1;
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // State, digit and term counters, and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dig       <= '0;
      term      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_PRE) || (state == ST_STEP)) begin
        dig <= dig_last ? '0 : dig + DIG_W'(1);
      end else begin
        dig <= '0;
      end
      if (cmd.start_eval) begin
        term <= CW'(1);
      end else if (cmd.load_term) begin
        term <= term + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gf2m_polynomial_evaluator.sv
`default_nettype none

// Channel     Transfer when            Payload
// input       in_valid & in_ready      command, coefficient_index, coefficient_value,
//                                      point_value
// result      out_valid & out_ready    eval_result
// config      cfg_valid & cfg_ready    cfg_index, cfg_data
//
// A coefficient write leaves the block idle, and a new item is accepted in the next cycle.
// An evaluation holds off new input until it is done. It first loads the constant term
// (or clears the sum when no term is in use) and reduces the point; then for each further
// term two interleaved multiply-reduce units, each consuming eight multiplier bits per
// cycle, form the term's product and the next power of the point, with NDIG = ceil(FIELD_BITS / 8).
// Reset (synchronous) restores the field polynomial and count; the coefficient
// store is not cleared. A pending result holds only the finish of the next evaluation.

module gf2m_polynomial_evaluator
  import gf2m_pkg::*;
#(
  parameter int MAX_COEFFS = 16,
  parameter int FIELD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [INDEX_W-1:0] coefficient_index,
  input  logic [ELEM_W-1:0]  coefficient_value,
  input  logic [ELEM_W-1:0]  point_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ELEM_W-1:0]  eval_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [POLY_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] rd_addr;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  gf2m_ctrl #(
    .MAX_COEFFS (MAX_COEFFS),
    .FIELD_BITS (FIELD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  gf2m_datapath #(
    .MAX_COEFFS (MAX_COEFFS),
    .FIELD_BITS (FIELD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .coefficient_index (coefficient_index),
    .coefficient_value (coefficient_value),
    .point_value       (point_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .status            (status),
    .eval_result       (eval_result)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gf2m_pkg::*;

  localparam int NUM_COEFFS    = 16;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 62;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 400000;

  // Tracks the field polynomial, the term count and the coefficient store, and
  // queues the polynomial value expected for every accepted evaluation.
  class poly_eval_scoreboard;
    logic [POLY_W-1:0]  field_poly;
    logic [COUNT_W-1:0] term_count;
    logic [ELEM_W-1:0]  coef_store [NUM_COEFFS];
    logic [ELEM_W-1:0]  expected_values [$];
    int                 mismatches;

    function new();
      field_poly = IRR_RESET;
      term_count = COUNT_RESET;
      foreach (coef_store[i]) coef_store[i] = '0;
      mismatches = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [POLY_W-1:0] data);
      if (idx == CFG_IRREDUCIBLE) begin
        field_poly = data;
      end else begin
        term_count = data[COUNT_W-1:0];
      end
    endfunction

    function logic [31:0] carryless_mul(logic [31:0] a, logic [31:0] b);
      logic [31:0] acc;
      acc = '0;
      for (int k = 0; k < 32; k++) begin
        if (b[k]) acc ^= a;
        a = a << 1;
      end
      return acc;
    endfunction

    // Long division by the field polynomial; a polynomial of degree zero or
    // less wipes out every product.
    function logic [31:0] reduce_mod(logic [31:0] v);
      logic [31:0] p;
      int          deg;
      p = {{(32-POLY_W){1'b0}}, field_poly};
      deg = -1;
      if (p < 2) return '0;
      for (int b = 0; b < POLY_W; b++) begin
        if (p[b]) deg = b;
      end
      for (int b = 31; b >= deg; b--) begin
        if (v[b]) v ^= p << (b - deg);
      end
      return v;
    endfunction

    // The constant term goes in as stored; the point itself is used
    // unreduced for the first product, its higher powers are reduced.
    function logic [ELEM_W-1:0] value_at(logic [ELEM_W-1:0] pt);
      int          n;
      logic [31:0] y;
      logic [31:0] x;
      n = (term_count > NUM_COEFFS) ? NUM_COEFFS : term_count;
      y = '0;
      x = 32'(pt);
      if (n > 0) begin
        y = 32'(coef_store[0]);
        for (int i = 1; i < n; i++) begin
          y ^= reduce_mod(carryless_mul(x, 32'(coef_store[i])));
          x = reduce_mod(carryless_mul(x, 32'(pt)));
        end
      end
      return y[ELEM_W-1:0];
    endfunction

    function void note_item(command_t cmd, logic [INDEX_W-1:0] idx,
                            logic [ELEM_W-1:0] cval, logic [ELEM_W-1:0] pt);
      if (cmd == CMD_WRITE) begin
        coef_store[idx] = cval;
      end else begin
        expected_values = {expected_values, value_at(pt)};
      end
    endfunction

    function void check_value(logic [ELEM_W-1:0] actual);
      logic [ELEM_W-1:0] want;
      if (expected_values.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("eval_result %h arrived with no evaluation outstanding", actual);
        return;
      end
      want = expected_values.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("eval_result mismatch: expected %h, got %h", want, actual);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = CMD_WRITE;
  logic [INDEX_W-1:0] coefficient_index = '0;
  logic [ELEM_W-1:0]  coefficient_value = '0;
  logic [ELEM_W-1:0]  point_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ELEM_W-1:0]  eval_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_IRREDUCIBLE;
  logic [POLY_W-1:0]  cfg_data = '0;

  poly_eval_scoreboard sb;
  logic [NUM_COEFFS-1:0] written_mask = '0;
  bit                    steady = 1'b0;
  int                    cycle_count = 0;

  gf2m_polynomial_evaluator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .coefficient_index(coefficient_index),
    .coefficient_value(coefficient_value),
    .point_value(point_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .eval_result(eval_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Field elements with the all-zero, all-one and single-bit values favoured.
  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 16'h0001;
      3: return 16'h8000;
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  // Presents one input item after an optional gap and waits for its transfer.
  task automatic send_item(command_t cmd, logic [INDEX_W-1:0] idx,
                           logic [ELEM_W-1:0] cval, logic [ELEM_W-1:0] pt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    command           <= cmd;
    coefficient_index <= idx;
    coefficient_value <= cval;
    point_value       <= pt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(cmd, idx, cval, pt);
  endtask

  task automatic write_coef(logic [INDEX_W-1:0] idx, logic [ELEM_W-1:0] cval);
    written_mask[idx] = 1'b1;
    send_item(CMD_WRITE, idx, cval, pick_element());
  endtask

  // An evaluation may only touch coefficients already written, so while the
  // terms in use are not all set the lowest missing one is written instead.
  task automatic issue_eval(logic [ELEM_W-1:0] pt);
    int                    n;
    logic [NUM_COEFFS:0]   need;
    logic [INDEX_W-1:0]    hole;
    n = (sb.term_count > NUM_COEFFS) ? NUM_COEFFS : sb.term_count;
    need = (17'd1 << n) - 17'd1;
    if ((written_mask & need[NUM_COEFFS-1:0]) == need[NUM_COEFFS-1:0]) begin
      send_item(CMD_EVAL, INDEX_W'($urandom_range(0, 15)), pick_element(), pt);
    end else begin
      hole = '0;
      for (int i = NUM_COEFFS - 1; i >= 0; i--) begin
        if (!written_mask[i]) hole = INDEX_W'(i);
      end
      write_coef(hole, pick_element());
    end
  endtask

  task automatic random_item();
    if ($urandom_range(0, 99) < 50) begin
      issue_eval(pick_element());
    end else begin
      write_coef(INDEX_W'($urandom_range(0, 15)), pick_element());
    end
  endtask

  task automatic write_register(cfg_reg_t idx, logic [POLY_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Upper data bits of the count write are junk the block must drop.
  task automatic apply_setting(logic [POLY_W-1:0] poly, logic [COUNT_W-1:0] count);
    logic [POLY_W-COUNT_W-1:0] junk;
    junk = (POLY_W-COUNT_W)'($urandom());
    write_register(CFG_IRREDUCIBLE, poly);
    write_register(CFG_COUNT, {junk, count});
    cfg_valid <= 1'b0;
  endtask

  // Let every expected result arrive, then give a trailing write time to finish.
  task automatic wait_idle();
    while (sb.expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure, one check per transfer.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_value(eval_result);
    end
  end

  initial begin
    logic [POLY_W-1:0]  poly;
    logic [COUNT_W-1:0] count;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset field (degree three) with three terms: an oversized constant term,
    // unreduced points and single-bit coefficients.
    write_coef(4'd0, 16'hFFFF);
    write_coef(4'd1, 16'h0001);
    write_coef(4'd2, 16'h0000);
    issue_eval(16'h0000);
    issue_eval(16'hFFFF);
    issue_eval(16'h0001);
    write_coef(4'd15, 16'hFFFF);
    write_coef(4'd2, 16'h8000);
    issue_eval(16'h8000);
    issue_eval(16'h0007);
    in_valid <= 1'b0;
    wait_idle();

    // Each phase picks a field and a term count: full degree, degree one,
    // degenerate polynomials, saturated and zero counts, then random ones.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin poly = 17'h1100B; count = 5'd16; end
        1: begin poly = 17'h00003; count = 5'd1;  end
        2: begin poly = 17'h00000; count = 5'd5;  end
        3: begin poly = 17'h00001; count = 5'd2;  end
        4: begin poly = 17'h1FFFF; count = 5'd31; end
        5: begin poly = 17'h0011D; count = 5'd0;  end
        6: begin poly = 17'h1002D; count = 5'd16; end
        default: begin
          poly  = POLY_W'($urandom_range(0, 131071));
          count = COUNT_W'($urandom_range(1, 16));
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      apply_setting(poly, count);
      issue_eval(16'h0000);
      issue_eval(16'hFFFF);
      repeat (PHASE_ITEMS) random_item();
      in_valid <= 1'b0;
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.expected_values.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
